// File: design/aik_pkg.sv
// Package for the arm inverse kinematics check: payload structs, register indexes,
// CORDIC arctangent table and shared widths. No dependencies.
package aik_pkg;

	localparam int CordicIterationsDefault = 16;
	localparam int CordicIterationsMax = 24;
	localparam int CfgIndexWidth = 3;
	localparam int CfgDataWidth = 16;

	// CORDIC datapath width: operands are normalized to 2^40, growth stays below 2^43.
	localparam int CordicWidth = 44;
	localparam int AngleWidth = 28;

	typedef enum logic [CfgIndexWidth-1:0] {
		REG_SHOULDER_LENGTH = 3'd0,
		REG_FOREARM_LENGTH  = 3'd1,
		REG_GROUND_LEVEL    = 3'd2,
		REG_REACH_LIMIT     = 3'd3,
		REG_SHOULDER_MAX    = 3'd4,
		REG_SHOULDER_MIN    = 3'd5,
		REG_ELBOW_LIMIT     = 3'd6
	} cfg_index_t;

	typedef struct packed {
		logic signed [15:0] target_x;
		logic signed [15:0] target_y;
		logic signed [15:0] target_z;
		logic [7:0]         grip_setting;
		logic [15:0]        hold_delay_ms;
	} target_t;

	typedef struct packed {
		logic               reachable;
		logic signed [15:0] shoulder_angle;
		logic signed [15:0] elbow_angle;
		logic signed [15:0] base_angle;
		logic [7:0]         grip_out;
		logic [15:0]        delay_out;
	} joint_t;

	typedef struct packed {
		logic [14:0]        shoulder_length;
		logic [14:0]        forearm_length;
		logic signed [15:0] ground_level;
		logic [15:0]        reach_limit;
		logic signed [15:0] shoulder_angle_max;
		logic signed [15:0] shoulder_angle_min;
		logic signed [15:0] elbow_angle_limit;
	} cfg_t;

	function automatic logic signed [AngleWidth-1:0] atan_entry(input int i);
		logic signed [AngleWidth-1:0] r;
		begin
			unique case (i)
				0: r = 28'sd2949120;
				1: r = 28'sd1740967;
				2: r = 28'sd919879;
				3: r = 28'sd466945;
				4: r = 28'sd234379;
				5: r = 28'sd117304;
				6: r = 28'sd58666;
				7: r = 28'sd29335;
				8: r = 28'sd14668;
				9: r = 28'sd7334;
				10: r = 28'sd3667;
				11: r = 28'sd1833;
				12: r = 28'sd917;
				13: r = 28'sd458;
				14: r = 28'sd229;
				15: r = 28'sd115;
				16: r = 28'sd57;
				17: r = 28'sd29;
				18: r = 28'sd14;
				19: r = 28'sd7;
				20: r = 28'sd4;
				21: r = 28'sd2;
				22: r = 28'sd1;
				default: r = '0;
			endcase
			return r;
		end
	endfunction

endpackage

// File: design/arm_inverse_kinematics_check.sv
// Top level of the arm inverse kinematics check: register file, squares, acos
// operands, three square roots, four CORDIC units and the final checks. Uses aik_pkg.
//
//   channel   signals                         handshake
//   target    start, busy, target             accepted when start && !busy
//   joint     done, joint                     one-cycle strobe, cannot be held off
//   config    cfg_valid, cfg_ready, cfg_*     written when cfg_valid && cfg_ready
//
// An item enters every cycle; busy is always low. The path runs through four setup
// stages, a 32-step square root, the CORDIC (Iterations + 2 stages) and two final
// stages. Reset clears only valid bits and configuration registers. Results never
// stall, so no item is ever held back or repeated.
module arm_inverse_kinematics_check import aik_pkg::*; #(
	parameter int CordicIterations = CordicIterationsDefault
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  target_t                  target,
	output logic                     done,
	output joint_t                   joint,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CfgIndexWidth-1:0] cfg_index,
	input  logic [CfgDataWidth-1:0]  cfg_data
);
	localparam int SqrtSteps = 32;
	localparam int RootLatency = SqrtSteps;
	localparam int CordicLatency = CordicIterations + 2;
	localparam int DelayLen = RootLatency + CordicLatency;

	cfg_t cfg_q;
	assign cfg_ready = 1'b1;
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SHOULDER_LENGTH: cfg_q.shoulder_length <= cfg_data[14:0];
				REG_FOREARM_LENGTH:  cfg_q.forearm_length <= cfg_data[14:0];
				REG_GROUND_LEVEL:    cfg_q.ground_level <= cfg_data;
				REG_REACH_LIMIT:     cfg_q.reach_limit <= cfg_data;
				REG_SHOULDER_MAX:    cfg_q.shoulder_angle_max <= cfg_data;
				REG_SHOULDER_MIN:    cfg_q.shoulder_angle_min <= cfg_data;
				REG_ELBOW_LIMIT:     cfg_q.elbow_angle_limit <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: squares.
	logic v_s1;
	target_t t_s1;
	logic [31:0] xx_s1, yy_s1, zz_s1, rr_s1, ss_s1, ff_s1;
	logic z_ok_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start;
	end
	always_ff @(posedge clk) begin
		t_s1 <= target;
		xx_s1 <= 32'(target.target_x) * 32'(target.target_x);
		yy_s1 <= 32'(target.target_y) * 32'(target.target_y);
		zz_s1 <= 32'(target.target_z) * 32'(target.target_z);
		rr_s1 <= 32'(cfg_q.reach_limit) * 32'(cfg_q.reach_limit);
		ss_s1 <= 32'(cfg_q.shoulder_length) * 32'(cfg_q.shoulder_length);
		ff_s1 <= 32'(cfg_q.forearm_length) * 32'(cfg_q.forearm_length);
		z_ok_s1 <= target.target_z > cfg_q.ground_level;
	end

	// Stage 2: distances and acos numerators.
	logic v_s2;
	target_t t_s2;
	logic [32:0] dxy2_s2;
	logic [33:0] dp2_s2;
	logic [31:0] ss_s2, ff_s2;
	logic signed [35:0] ca_s2, cb_s2;
	logic in_range_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		logic [33:0] dp2;
		dp2 = 34'(xx_s1) + 34'(yy_s1) + 34'(zz_s1);
		t_s2 <= t_s1;
		dxy2_s2 <= 33'(xx_s1) + 33'(yy_s1);
		dp2_s2 <= dp2;
		ss_s2 <= ss_s1;
		ff_s2 <= ff_s1;
		// c = -(F^2 - S^2 - dp^2) and c = -(dp^2 - S^2 - F^2)
		ca_s2 <= 36'(signed'({2'b0, dp2})) + 36'(ss_s1) - 36'(ff_s1);
		cb_s2 <= 36'(ss_s1) + 36'(ff_s1) - 36'(signed'({2'b0, dp2}));
		in_range_s2 <= (dp2 < 34'(rr_s1)) && z_ok_s1;
	end

	// Stage 3 and 4: squares of the acos denominators and numerators, split over two
	// stages as 34x34 products.
	logic v_s3;
	target_t t_s3;
	logic [32:0] dxy2_s3;
	logic [33:0] dp2_s3;
	logic [31:0] ss_s3;
	logic [63:0] sf_s3;
	logic signed [35:0] ca_s3, cb_s3;
	logic [69:0] ca2_s3, cb2_s3;
	logic in_range_s3, a_def_s3, b_def_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		logic [35:0] ma, mb;
		ma = ca_s2[35] ? 36'(-ca_s2) : 36'(ca_s2);
		mb = cb_s2[35] ? 36'(-cb_s2) : 36'(cb_s2);
		t_s3 <= t_s2;
		dxy2_s3 <= dxy2_s2;
		dp2_s3 <= dp2_s2;
		ss_s3 <= ss_s2;
		sf_s3 <= 64'(ss_s2) * 64'(ff_s2);
		ca_s3 <= ca_s2;
		cb_s3 <= cb_s2;
		// Both numerator magnitudes stay below 2^33.
		ca2_s3 <= 70'(ma[33:0]) * 70'(ma[33:0]);
		cb2_s3 <= 70'(mb[33:0]) * 70'(mb[33:0]);
		in_range_s3 <= in_range_s2;
		a_def_s3 <= (ss_s2 != '0) && (dp2_s2 != '0);
		b_def_s3 <= (ss_s2 != '0) && (ff_s2 != '0);
	end

	logic v_s4;
	target_t t_s4;
	logic [63:0] rada_s4, radb_s4, radxy_s4;
	logic signed [35:0] ca_s4, cb_s4;
	logic signed [35:0] zz_s4;
	logic in_range_s4, a_ok_s4, b_ok_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		logic [69:0] da2, db2;
		da2 = (70'(ss_s3) * 70'(dp2_s3)) << 2;
		db2 = 70'(sf_s3) << 2;
		t_s4 <= t_s3;
		ca_s4 <= ca_s3;
		cb_s4 <= cb_s3;
		zz_s4 <= 36'(t_s3.target_z) <<< 8;
		in_range_s4 <= in_range_s3;
		a_ok_s4 <= a_def_s3 && (ca2_s3 <= da2);
		b_ok_s4 <= b_def_s3 && (cb2_s3 <= db2);
		rada_s4 <= 64'(da2 - ca2_s3);
		radb_s4 <= 64'(db2 - cb2_s3);
		radxy_s4 <= {15'd0, dxy2_s3, 16'd0};
	end

	// Three square roots in parallel; the tag of the first root carries the side data.
	localparam int TagW = $bits(target_t) + 36 * 3 + 3;
	logic [TagW-1:0] tag_in, tag_r;
	logic [31:0] root_a, root_b, root_xy;
	logic vr, vr_b, vr_xy;
	logic [0:0] unused_b, unused_xy;
	assign tag_in = {t_s4, ca_s4, cb_s4, zz_s4, in_range_s4, a_ok_s4, b_ok_s4};

	aik_isqrt #(.InWidth(64), .TagWidth(TagW)) u_sqrt_a (
		.clk, .arst_n, .in_valid(v_s4), .in_radicand(rada_s4), .in_tag(tag_in),
		.out_valid(vr), .out_root(root_a), .out_tag(tag_r));
	aik_isqrt #(.InWidth(64), .TagWidth(1)) u_sqrt_b (
		.clk, .arst_n, .in_valid(v_s4), .in_radicand(radb_s4), .in_tag(1'b0),
		.out_valid(vr_b), .out_root(root_b), .out_tag(unused_b));
	aik_isqrt #(.InWidth(64), .TagWidth(1)) u_sqrt_xy (
		.clk, .arst_n, .in_valid(v_s4), .in_radicand(radxy_s4), .in_tag(1'b0),
		.out_valid(vr_xy), .out_root(root_xy), .out_tag(unused_xy));

	target_t tr;
	logic signed [35:0] car, cbr, zzr;
	logic rng_r, aok_r, bok_r;
	assign {tr, car, cbr, zzr, rng_r, aok_r, bok_r} = tag_r;

	logic signed [AngleWidth-1:0] ang_th, ang_a1, ang_a2, ang_b2;
	logic vc, vc1, vc2, vc3;
	logic [$bits(target_t)+2:0] ctag;
	logic [0:0] ut1, ut2, ut3;

	aik_cordic #(.Iterations(CordicIterations), .TagWidth($bits(target_t) + 3)) u_theta (
		.clk, .arst_n, .in_valid(vr),
		.in_y(36'(tr.target_y)), .in_x(36'(tr.target_x)),
		.in_tag({tr, rng_r, aok_r, bok_r}),
		.out_valid(vc), .out_angle(ang_th), .out_tag(ctag));
	aik_cordic #(.Iterations(CordicIterations), .TagWidth(1)) u_a1 (
		.clk, .arst_n, .in_valid(vr_xy), .in_y(zzr), .in_x(36'(root_xy)),
		.in_tag(1'b0), .out_valid(vc1), .out_angle(ang_a1), .out_tag(ut1));
	aik_cordic #(.Iterations(CordicIterations), .TagWidth(1)) u_a2 (
		.clk, .arst_n, .in_valid(vr_b), .in_y(36'(root_a)), .in_x(car),
		.in_tag(1'b0), .out_valid(vc2), .out_angle(ang_a2), .out_tag(ut2));
	aik_cordic #(.Iterations(CordicIterations), .TagWidth(1)) u_b2 (
		.clk, .arst_n, .in_valid(vr_b), .in_y(36'(root_b)), .in_x(cbr),
		.in_tag(1'b0), .out_valid(vc3), .out_angle(ang_b2), .out_tag(ut3));

	target_t tc;
	logic rng_c, aok_c, bok_c;
	assign {tc, rng_c, aok_c, bok_c} = ctag;

	// Final stage 1: sum and round to 1/64 degree.
	logic v_f1;
	target_t t_f1;
	logic signed [17:0] al_f1, be_f1, th_f1;
	logic rng_f1, aok_f1, bok_f1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_f1 <= 1'b0;
		else v_f1 <= vc && vc1 && vc2 && vc3;
	end
	always_ff @(posedge clk) begin
		logic signed [AngleWidth+1:0] sa, sb, st;
		sa = 30'(ang_a1) + 30'(ang_a2) + 30'(90 * 65536 + 512);
		sb = 30'(ang_b2) - 30'(180 * 65536) + 30'sd512;
		st = 30'(ang_th) + 30'sd512;
		t_f1 <= tc;
		al_f1 <= 18'(sa >>> 10);
		be_f1 <= 18'(sb >>> 10);
		th_f1 <= 18'(st >>> 10);
		rng_f1 <= rng_c;
		aok_f1 <= rng_c && aok_c;
		bok_f1 <= rng_c && bok_c;
	end

	// Final stage 2: limit checks and output register.
	logic v_f2;
	joint_t j_f2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_f2 <= 1'b0;
		else v_f2 <= v_f1;
	end
	always_ff @(posedge clk) begin
		logic signed [17:0] bound, lim;
		logic in_lim;
		bound = 18'sd11520 - al_f1;
		lim = 18'(cfg_q.elbow_angle_limit);
		if (lim < bound) bound = lim;
		in_lim = (al_f1 <= 18'(cfg_q.shoulder_angle_max)) &&
			(al_f1 >= 18'(cfg_q.shoulder_angle_min));
		j_f2.reachable <= aok_f1 && bok_f1 && in_lim && (be_f1 < bound);
		j_f2.shoulder_angle <= aok_f1 ? 16'(al_f1) : '0;
		j_f2.elbow_angle <= bok_f1 ? 16'(be_f1) : '0;
		j_f2.base_angle <= rng_f1 ? 16'(th_f1) : '0;
		j_f2.grip_out <= t_f1.grip_setting;
		j_f2.delay_out <= t_f1.hold_delay_ms;
	end

	assign done = v_f2;
	assign joint = j_f2;

	localparam int Total = DelayLen + 6;
	a_reach_needs_angles: assert property (@(posedge clk) disable iff (!arst_n)
		done && joint.reachable |-> joint.shoulder_angle >= cfg_q.shoulder_angle_min)
		else $error("reachable item outside shoulder limits");
	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		vc == vc1 && vc == vc2 && vc == vc3)
		else $error("CORDIC lanes out of step");
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> ##(Total - 4) done)
		else $error("item lost in pipeline");
endmodule

// File: design/aik_isqrt.sv
// Pipelined integer square root, one result bit per stage, floor result.
// Depends on nothing but its parameters.
module aik_isqrt #(
	parameter int InWidth = 64,
	parameter int TagWidth = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic [InWidth-1:0]     in_radicand,
	input  logic [TagWidth-1:0]    in_tag,
	output logic                   out_valid,
	output logic [InWidth/2-1:0]   out_root,
	output logic [TagWidth-1:0]    out_tag
);
	localparam int Steps = InWidth / 2;

	logic                        vld_s [Steps+1];
	logic [InWidth-1:0]          rem_s [Steps+1];
	logic [InWidth-1:0]          rad_s [Steps+1];
	logic [Steps-1:0]            root_s [Steps+1];
	logic [TagWidth-1:0]         tag_s [Steps+1];

	assign vld_s[0] = in_valid;
	assign rem_s[0] = '0;
	assign rad_s[0] = in_radicand;
	assign root_s[0] = '0;
	assign tag_s[0] = in_tag;

	for (genvar k = 0; k < Steps; k++) begin : g_step
		// Restoring digit step: bring down two radicand bits, trial subtract 4r+1.
		logic [InWidth+1:0] rem_w;
		logic [InWidth+1:0] trial;
		always_comb begin
			rem_w = {rem_s[k], rad_s[k][InWidth-1 -: 2]};
			trial = {{(InWidth-Steps){1'b0}}, root_s[k], 2'b01};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end
		always_ff @(posedge clk) begin
			tag_s[k+1] <= tag_s[k];
			rad_s[k+1] <= {rad_s[k][InWidth-3:0], 2'b00};
			if (rem_w >= trial) begin
				rem_s[k+1] <= InWidth'(rem_w - trial);
				root_s[k+1] <= {root_s[k][Steps-2:0], 1'b1};
			end else begin
				rem_s[k+1] <= InWidth'(rem_w);
				root_s[k+1] <= {root_s[k][Steps-2:0], 1'b0};
			end
		end
	end

	assign out_valid = vld_s[Steps];
	assign out_root = root_s[Steps];
	assign out_tag = tag_s[Steps];
endmodule

// File: design/aik_cordic.sv
// Pipelined vectoring CORDIC giving atan2(y, x) in 2^-16 degree units.
// Normalization, quadrant pre-rotation and one micro-rotation per stage; uses aik_pkg.
module aik_cordic import aik_pkg::*; #(
	parameter int Iterations = CordicIterationsDefault,
	parameter int TagWidth = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic signed [35:0]            in_y,
	input  logic signed [35:0]            in_x,
	input  logic [TagWidth-1:0]           in_tag,
	output logic                          out_valid,
	output logic signed [AngleWidth-1:0]  out_angle,
	output logic [TagWidth-1:0]           out_tag
);
	localparam int W = CordicWidth;
	localparam logic signed [AngleWidth-1:0] Quarter = AngleWidth'(90 * 65536);

	// Stage 1: leading-bit shift so that the larger magnitude lands in [2^40, 2^41).
	logic [35:0] mx, my, mor;
	logic [5:0]  lz;
	always_comb begin
		mx = in_x[35] ? 36'(-in_x) : 36'(in_x);
		my = in_y[35] ? 36'(-in_y) : 36'(in_y);
		mor = mx | my;
		lz = 6'd0;
		for (int b = 0; b < 36; b++) begin
			if (mor[b]) lz = 6'(35 - b);
		end
	end

	logic                   v_s1;
	logic signed [W-1:0]    x_s1, y_s1;
	logic                   zero_s1;
	logic [TagWidth-1:0]    tag_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		// Doubling stops once one magnitude reaches 2^40, i.e. msb at bit 40.
		x_s1 <= W'(signed'(in_x)) <<< (lz + 6'd5);
		y_s1 <= W'(signed'(in_y)) <<< (lz + 6'd5);
		zero_s1 <= (mor == '0);
		tag_s1 <= in_tag;
	end

	// Stage 2: pre-rotate out of the left half plane.
	logic                        v_s2;
	logic signed [W-1:0]         x_s2, y_s2;
	logic signed [AngleWidth-1:0] a_s2;
	logic                        zero_s2;
	logic [TagWidth-1:0]         tag_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		zero_s2 <= zero_s1;
		tag_s2 <= tag_s1;
		if (x_s1 < 0 && y_s1 >= 0) begin
			x_s2 <= y_s1;
			y_s2 <= -x_s1;
			a_s2 <= Quarter;
		end else if (x_s1 < 0) begin
			x_s2 <= -y_s1;
			y_s2 <= x_s1;
			a_s2 <= -Quarter;
		end else begin
			x_s2 <= x_s1;
			y_s2 <= y_s1;
			a_s2 <= '0;
		end
	end

	logic                         v_r [Iterations+1];
	logic signed [W-1:0]          x_r [Iterations+1];
	logic signed [W-1:0]          y_r [Iterations+1];
	logic signed [AngleWidth-1:0] a_r [Iterations+1];
	logic                         z_r [Iterations+1];
	logic [TagWidth-1:0]          t_r [Iterations+1];

	assign v_r[0] = v_s2;
	assign x_r[0] = x_s2;
	assign y_r[0] = y_s2;
	assign a_r[0] = a_s2;
	assign z_r[0] = zero_s2;
	assign t_r[0] = tag_s2;

	for (genvar i = 0; i < Iterations; i++) begin : g_rot
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_r[i+1] <= 1'b0;
			end else begin
				v_r[i+1] <= v_r[i];
			end
		end
		always_ff @(posedge clk) begin
			z_r[i+1] <= z_r[i];
			t_r[i+1] <= t_r[i];
			if (y_r[i] > 0) begin
				x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
				y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
				a_r[i+1] <= a_r[i] + atan_entry(i);
			end else begin
				x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
				y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
				a_r[i+1] <= a_r[i] - atan_entry(i);
			end
		end
	end

	assign out_valid = v_r[Iterations];
	assign out_angle = z_r[Iterations] ? '0 : a_r[Iterations];
	assign out_tag = t_r[Iterations];
endmodule
